>>> sv/ssdd_pkg.sv
`timescale 1ns / 1ps
// ssdd_pkg: shared types, register indexes and segment tables of the
// segment scan display driver. No dependencies.

package ssdd_pkg;

    localparam int CFG_IDX_BITS = 3;
    localparam int SLOT_BITS    = 3;
    localparam int STEP_BITS    = 3;
    localparam int SEG_BITS     = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_BIG_NUMBER    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RANGE_START   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RANGE_END     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BLANK         = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HYPHEN_HIDDEN = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DWELL_TICKS   = 3'd5;

    localparam logic [SLOT_BITS-1:0] SLOT_BIG_UNITS    = 3'd0;
    localparam logic [SLOT_BITS-1:0] SLOT_BIG_TENS     = 3'd1;
    localparam logic [SLOT_BITS-1:0] SLOT_BIG_HUNDREDS = 3'd2;
    localparam logic [SLOT_BITS-1:0] SLOT_END_UNITS    = 3'd3;
    localparam logic [SLOT_BITS-1:0] SLOT_END_TENS     = 3'd4;
    localparam logic [SLOT_BITS-1:0] SLOT_BEGIN_UNITS  = 3'd5;
    localparam logic [SLOT_BITS-1:0] SLOT_BEGIN_TENS   = 3'd6;
    localparam logic [SLOT_BITS-1:0] SLOT_NONE         = 3'd7;

    localparam logic [9:0] BIG_MAX       = 10'd999;
    localparam logic [4:0] RANGE_LIMIT   = 5'd20;
    localparam logic [4:0] RANGE_TEN     = 5'd10;
    localparam int         HYPHEN_BIT    = 7;

    typedef struct packed {
        logic [9:0]  big_number;
        logic [4:0]  range_start;
        logic [4:0]  range_end;
        logic        blank;
        logic        hyphen_hidden;
        logic [15:0] dwell_ticks;
    } t_cfg;

    typedef struct packed {
        logic [SLOT_BITS-1:0] digit_select;
        logic [7:0]           segment_drive;
        logic                 pass_done;
    } t_scan_out;

    // number of lit segments of a numeral
    function automatic logic [STEP_BITS-1:0] seg_count(input logic [3:0] d);
        logic [STEP_BITS-1:0] c;
        unique case (d)
            4'd0:    c = 3'd6;
            4'd1:    c = 3'd2;
            4'd2:    c = 3'd5;
            4'd3:    c = 3'd5;
            4'd4:    c = 3'd4;
            4'd5:    c = 3'd5;
            4'd6:    c = 3'd6;
            4'd7:    c = 3'd3;
            4'd8:    c = 3'd7;
            4'd9:    c = 3'd6;
            default: c = 3'd0;
        endcase
        return c;
    endfunction

    // segment lit at a given step of a numeral
    function automatic logic [SEG_BITS-1:0] seg_code(input logic [3:0] d,
                                                     input logic [STEP_BITS-1:0] step);
        logic [7:0][SEG_BITS-1:0] row;
        unique case (d)
            4'd0: row = {3'd0, 3'd0, 3'd6, 3'd5, 3'd4, 3'd2, 3'd1, 3'd0};
            4'd1: row = {3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd4, 3'd1};
            4'd2: row = {3'd0, 3'd0, 3'd0, 3'd6, 3'd5, 3'd3, 3'd1, 3'd0};
            4'd3: row = {3'd0, 3'd0, 3'd0, 3'd6, 3'd4, 3'd3, 3'd1, 3'd0};
            4'd4: row = {3'd0, 3'd0, 3'd0, 3'd0, 3'd4, 3'd3, 3'd1, 3'd2};
            4'd5: row = {3'd0, 3'd0, 3'd0, 3'd6, 3'd4, 3'd3, 3'd2, 3'd0};
            4'd6: row = {3'd0, 3'd0, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd0};
            4'd7: row = {3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd4, 3'd1, 3'd0};
            4'd8: row = {3'd0, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
            4'd9: row = {3'd0, 3'd0, 3'd6, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
            default: row = '0;
        endcase
        return row[step];
    endfunction

endpackage

>>> sv/ssdd_scan.sv
`timescale 1ns / 1ps
// ssdd_scan: scan position, segment step and dwell counter with the
// output decode of the current position. Depends on ssdd_pkg.

module ssdd_scan #(
    parameter int DWELL_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ssdd_pkg::t_cfg     i_cfg,
    input  logic               i_fire,
    input  logic               i_tick,
    output ssdd_pkg::t_scan_out o_res
);

    localparam int WW = (DWELL_BITS > 16 ? DWELL_BITS : 16) + 1;
    localparam logic [WW-1:0] MAXC = WW'((64'd1 << DWELL_BITS) - 64'd1);

    logic [ssdd_pkg::SLOT_BITS-1:0] r_slot, n_slot;
    logic [ssdd_pkg::STEP_BITS-1:0] r_step, n_step;
    logic [DWELL_BITS-1:0]          r_count, n_count;

    logic [9:0]  big;
    logic [17:0] prod10;
    logic [15:0] prod100;
    logic [6:0]  q10;
    logic [3:0]  q100;
    logic [9:0]  t10;
    logic [6:0]  t100;
    logic [3:0]  big_units, big_tens, end_units, start_units;
    logic        end_ok, start_ok;
    logic [7:0]  shown;
    logic [7:0][3:0] digit;

    logic [3:0]                     cur_digit;
    logic [ssdd_pkg::STEP_BITS-1:0] cur_cnt;
    logic                           cur_valid;
    logic [ssdd_pkg::SEG_BITS-1:0]  cur_seg;
    logic [3:0]                     step_inc;

    logic [WW-1:0] dwell_ext, dwell_eff, count_inc;

    logic                           later_found, first_found;
    logic [ssdd_pkg::SLOT_BITS-1:0] later_slot, first_slot, wrap_slot;

    function automatic logic [ssdd_pkg::SLOT_BITS-1:0] SLOT_BITS_CAST(input int v);
        return v[ssdd_pkg::SLOT_BITS-1:0];
    endfunction

    // digit split of the big number and the range ends, and the shown flag of each position
    always_comb begin
        big     = (i_cfg.big_number > ssdd_pkg::BIG_MAX) ? ssdd_pkg::BIG_MAX
                                                         : i_cfg.big_number;
        prod10  = 18'(big) * 18'd205;
        prod100 = 16'(big) * 16'd41;
        q10     = 7'(prod10 >> 11);
        q100    = 4'(prod100 >> 12);
        t10     = 10'(q10) * 10'd10;
        t100    = 7'(q100) * 7'd10;
        big_units = 4'(big - t10);
        big_tens  = 4'(q10 - t100);
        end_units   = 4'((i_cfg.range_end >= ssdd_pkg::RANGE_TEN)
                         ? i_cfg.range_end - ssdd_pkg::RANGE_TEN : i_cfg.range_end);
        start_units = 4'((i_cfg.range_start >= ssdd_pkg::RANGE_TEN)
                         ? i_cfg.range_start - ssdd_pkg::RANGE_TEN : i_cfg.range_start);
        end_ok   = (i_cfg.range_end != 5'd0) && (i_cfg.range_end < ssdd_pkg::RANGE_LIMIT);
        start_ok = (i_cfg.range_start != 5'd0)
                   && (i_cfg.range_start < ssdd_pkg::RANGE_LIMIT);

        shown[ssdd_pkg::SLOT_BIG_UNITS]    = big != 10'd0;
        shown[ssdd_pkg::SLOT_BIG_TENS]     = big > 10'd9;
        shown[ssdd_pkg::SLOT_BIG_HUNDREDS] = big > 10'd99;
        shown[ssdd_pkg::SLOT_END_UNITS]    = end_ok;
        shown[ssdd_pkg::SLOT_END_TENS]     = end_ok && (i_cfg.range_end >= ssdd_pkg::RANGE_TEN);
        shown[ssdd_pkg::SLOT_BEGIN_UNITS]  = start_ok;
        shown[ssdd_pkg::SLOT_BEGIN_TENS]   = start_ok
                                             && (i_cfg.range_start >= ssdd_pkg::RANGE_TEN);
        shown[ssdd_pkg::SLOT_NONE]         = 1'b0;
        if (i_cfg.blank) begin
            shown = '0;
        end

        digit[ssdd_pkg::SLOT_BIG_UNITS]    = big_units;
        digit[ssdd_pkg::SLOT_BIG_TENS]     = big_tens;
        digit[ssdd_pkg::SLOT_BIG_HUNDREDS] = q100;
        digit[ssdd_pkg::SLOT_END_UNITS]    = end_units;
        digit[ssdd_pkg::SLOT_END_TENS]     = 4'd1;
        digit[ssdd_pkg::SLOT_BEGIN_UNITS]  = start_units;
        digit[ssdd_pkg::SLOT_BEGIN_TENS]   = 4'd1;
        digit[ssdd_pkg::SLOT_NONE]         = 4'd0;
    end

    // next shown position after the current one, else first of the pass
    always_comb begin
        later_found = 1'b0;
        later_slot  = '0;
        first_found = 1'b0;
        first_slot  = '0;
        for (int s = 6; s >= 0; s--) begin
            if (shown[s]) begin
                first_found = 1'b1;
                first_slot  = SLOT_BITS_CAST(s);
                if (SLOT_BITS_CAST(s) > r_slot) begin
                    later_found = 1'b1;
                    later_slot  = SLOT_BITS_CAST(s);
                end
            end
        end
        wrap_slot = first_found ? first_slot : ssdd_pkg::SLOT_BIG_UNITS;
    end

    always_comb begin
        cur_digit = digit[r_slot];
        cur_cnt   = ssdd_pkg::seg_count(cur_digit);
        cur_seg   = ssdd_pkg::seg_code(cur_digit, r_step);
        cur_valid = shown[r_slot] && (r_step <= cur_cnt);
        step_inc  = {1'b0, r_step} + 4'd1;

        dwell_ext = WW'(i_cfg.dwell_ticks);
        priority if (dwell_ext == '0) begin
            dwell_eff = WW'(1);
        end else if (dwell_ext > MAXC) begin
            dwell_eff = MAXC;
        end else begin
            dwell_eff = dwell_ext;
        end
        count_inc = WW'(r_count) + WW'(1);

        o_res.digit_select  = ssdd_pkg::SLOT_NONE;
        o_res.segment_drive = '0;
        o_res.pass_done     = 1'b0;
        if (cur_valid) begin
            o_res.digit_select = r_slot;
            if (r_step < cur_cnt) begin
                o_res.segment_drive[6:0] = 7'd1 << cur_seg;
            end
            if ((r_slot == ssdd_pkg::SLOT_END_UNITS || r_slot == ssdd_pkg::SLOT_END_TENS)
                && !i_cfg.hyphen_hidden) begin
                o_res.segment_drive[ssdd_pkg::HYPHEN_BIT] = 1'b1;
            end
        end

        n_slot  = r_slot;
        n_step  = r_step;
        n_count = r_count;
        if (i_tick) begin
            priority if (!cur_valid || (count_inc >= dwell_eff
                                        && step_inc > {1'b0, cur_cnt})) begin
                n_step  = '0;
                n_count = '0;
                n_slot  = later_found ? later_slot : wrap_slot;
                o_res.pass_done = !later_found;
            end else if (count_inc < dwell_eff) begin
                n_count = count_inc[DWELL_BITS-1:0];
            end else begin
                n_count = '0;
                n_step  = step_inc[ssdd_pkg::STEP_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= ssdd_pkg::SLOT_BIG_UNITS;
            r_step  <= '0;
            r_count <= '0;
        end else if (i_fire) begin
            r_slot  <= n_slot;
            r_step  <= n_step;
            r_count <= n_count;
        end
    end

endmodule

>>> sv/segment_scan_display_driver_core.sv
`timescale 1ns / 1ps
// segment_scan_display_driver_core: top level with configuration registers,
// input stage and result register. Depends on ssdd_pkg and ssdd_scan.

// Each tick transfer yields one result transfer, passing the input register and then
// the result register; one tick is taken every clock while results are drained, the
// rate being set by the update of the scan counters between the input register and the
// result register. While a result is held by i_out_stall, the input is stalled in
// the same clock once the input register holds a tick. Configuration writes are
// always ready and take effect on the next tick.

module segment_scan_display_driver_core #(
    parameter int DWELL_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_tick,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_digit_select,
    output logic [7:0]  o_segment_drive,
    output logic        o_pass_done,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [ssdd_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    ssdd_pkg::t_cfg      r_cfg;
    ssdd_pkg::t_scan_out scan_res;
    logic                r_in_valid;
    logic                r_tick;
    logic                r_out_valid;
    logic                advance;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.big_number    <= '0;
            r_cfg.range_start   <= '0;
            r_cfg.range_end     <= '0;
            r_cfg.blank         <= 1'b0;
            r_cfg.hyphen_hidden <= 1'b0;
            r_cfg.dwell_ticks   <= 16'd100;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                ssdd_pkg::CFG_BIG_NUMBER:    r_cfg.big_number    <= i_cfg_data[9:0];
                ssdd_pkg::CFG_RANGE_START:   r_cfg.range_start   <= i_cfg_data[4:0];
                ssdd_pkg::CFG_RANGE_END:     r_cfg.range_end     <= i_cfg_data[4:0];
                ssdd_pkg::CFG_BLANK:         r_cfg.blank         <= i_cfg_data[0];
                ssdd_pkg::CFG_HYPHEN_HIDDEN: r_cfg.hyphen_hidden <= i_cfg_data[0];
                ssdd_pkg::CFG_DWELL_TICKS:   r_cfg.dwell_ticks   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_tick <= i_tick;
        end
    end

    ssdd_scan #(
        .DWELL_BITS (DWELL_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_fire  (advance),
        .i_tick  (r_tick),
        .o_res   (scan_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            o_digit_select  <= scan_res.digit_select;
            o_segment_drive <= scan_res.segment_drive;
            o_pass_done     <= scan_res.pass_done;
        end
    end

    assign o_out_valid = r_out_valid;

    a_dark_when_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_digit_select == ssdd_pkg::SLOT_NONE |-> o_segment_drive == 8'd0)
        else $error("segments lit with no digit enabled");

    a_one_segment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0(o_segment_drive[6:0]))
        else $error("more than one segment lit");

    a_hyphen_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_segment_drive[ssdd_pkg::HYPHEN_BIT]
        |-> (o_digit_select == ssdd_pkg::SLOT_END_UNITS
             || o_digit_select == ssdd_pkg::SLOT_END_TENS))
        else $error("hyphen outside end digits");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_out_valid && i_out_stall)
        else $error("input stalled while result register free");

endmodule
